// File: design/pvma_pkg.sv
// ----------------------------------------------------------------------------
// Moving average package
// Widths, defaults and the controller command/status types shared by the block.
// ----------------------------------------------------------------------------
package pvma_pkg;

  localparam int VolumesDefault   = 64;
  localparam int MaxWindowDefault = 16;
  localparam int VolW    = 6;
  localparam int BwW     = 40;
  localparam int IopsW   = 32;
  localparam int LenW    = 5;
  localparam int NumW    = 48;   // avg*L + new fits in 40+5+1 bits, rounded up
  localparam int DivCntW = 6;
  localparam logic [LenW-1:0] LenReset = LenW'(4);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the accepted transaction and look up state
    logic rd_ring;   // issue ring read of the evicted slot
    logic setup;     // form numerators from state and ring data
    logic div_start; // start the shared divider for both averages
    logic commit;    // write state and ring, register the result
  } pvma_cmd_t;

  typedef struct packed {
    logic div_done;
  } pvma_sts_t;

endpackage

// File: design/pvma_ctrl.sv
// ----------------------------------------------------------------------------
// Moving average controller
// Sequences lookup, ring read, setup, two divisions and commit for one item.
// ----------------------------------------------------------------------------
module pvma_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  output pvma_pkg::pvma_cmd_t cmd,
  input  pvma_pkg::pvma_sts_t sts
);
  import pvma_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_RING, S_SETUP, S_START, S_DIV, S_COMMIT} state_t;
  state_t state;

  // The result register frees as soon as it is taken, so a new transaction
  // may enter while the previous result still waits.
  assign s_tready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.load      = (state == S_IDLE) && s_tvalid;
    cmd.rd_ring   = (state == S_RING);
    cmd.setup     = (state == S_SETUP);
    cmd.div_start = (state == S_START);
    cmd.commit    = (state == S_COMMIT) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.commit) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE:   if (s_tvalid) state <= S_RING;
        S_RING:   state <= S_SETUP;
        S_SETUP:  state <= S_START;
        S_START:  state <= S_DIV;
        S_DIV:    if (sts.div_done) state <= S_COMMIT;
        S_COMMIT: if (cmd.commit) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end
endmodule

// File: design/pvma_datapath.sv
// ----------------------------------------------------------------------------
// Moving average datapath
// Per-volume state, sample rings and a shared restoring divider for both
// averages, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pvma_datapath #(
  parameter int VOLUMES    = pvma_pkg::VolumesDefault,
  parameter int MAX_WINDOW = pvma_pkg::MaxWindowDefault
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [pvma_pkg::LenW-1:0]   window_length,
  input  logic [pvma_pkg::VolW-1:0]   volume_id,
  input  logic [pvma_pkg::BwW-1:0]    bw_sample,
  input  logic [pvma_pkg::IopsW-1:0]  iops_sample,
  input  pvma_pkg::pvma_cmd_t         cmd,
  output pvma_pkg::pvma_sts_t         sts,
  output logic                        ready_res,
  output logic [pvma_pkg::BwW-1:0]    avg_bw,
  output logic [pvma_pkg::IopsW-1:0]  avg_iops
);
  import pvma_pkg::*;

  localparam int VIdxW = (VOLUMES > 1) ? $clog2(VOLUMES) : 1;
  localparam int PosW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WinW  = $clog2(MAX_WINDOW + 1);
  localparam int FlW   = (WinW > LenW) ? WinW : LenW;
  localparam int OpW   = FlW + 1;
  localparam int RingD = VOLUMES << PosW;
  localparam int RAddrW = VIdxW + PosW;
  localparam int SumBwW = BwW + WinW;
  localparam int SumIoW = IopsW + WinW;

  // Per-volume state in memories; valid bits give the reset value of zero.
  logic [PosW-1:0]   pos_mem  [VOLUMES];
  logic [FlW-1:0]    fill_mem [VOLUMES];
  logic [SumBwW-1:0] sbw_mem  [VOLUMES];
  logic [SumIoW-1:0] sio_mem  [VOLUMES];
  logic [BwW-1:0]    abw_mem  [VOLUMES];
  logic [IopsW-1:0]  aio_mem  [VOLUMES];
  logic [VOLUMES-1:0] vld;
  logic [VOLUMES-1:0] rdy;
  logic [BwW-1:0]    ring_bw   [RingD];
  logic [IopsW-1:0]  ring_iops [RingD];

  logic [VolW-1:0]   vol;
  logic [BwW-1:0]    bw;
  logic [IopsW-1:0]  io;
  logic              in_range;
  logic [VIdxW-1:0]  vi;
  logic [VIdxW-1:0]  vi_in;
  logic [FlW-1:0]    len;
  logic [PosW-1:0]   pos_r;
  logic [FlW-1:0]    fill_r;
  logic [SumBwW-1:0] sbw_r;
  logic [SumIoW-1:0] sio_r;
  logic [BwW-1:0]    abw_r;
  logic [IopsW-1:0]  aio_r;
  logic              vld_r, rdy_r;
  logic [BwW-1:0]    old_bw;
  logic [IopsW-1:0]  old_io;
  logic              filling, completes;

  // Effective window length: zero acts as one, large values clamp.
  logic [FlW-1:0] len_next;
  always_comb begin
    if (window_length == '0) len_next = FlW'(1);
    else if (FlW'(window_length) > FlW'(MAX_WINDOW)) len_next = FlW'(MAX_WINDOW);
    else len_next = FlW'(window_length);
  end

  assign vi    = VIdxW'(vol);
  assign vi_in = VIdxW'(volume_id);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vol      <= volume_id;
      bw       <= bw_sample;
      io       <= iops_sample;
      len      <= len_next;
      in_range <= ({26'd0, volume_id} < 32'(VOLUMES));
      pos_r    <= pos_mem[vi_in];
      fill_r   <= fill_mem[vi_in];
      sbw_r    <= sbw_mem[vi_in];
      sio_r    <= sio_mem[vi_in];
      abw_r    <= abw_mem[vi_in];
      aio_r    <= aio_mem[vi_in];
      vld_r    <= vld[vi_in];
      rdy_r    <= rdy[vi_in];
    end
  end

  // Clear looked-up values for a volume never touched since reset.
  logic [PosW-1:0]   pos_e;
  logic [FlW-1:0]    fill_e;
  logic [SumBwW-1:0] sbw_e;
  logic [SumIoW-1:0] sio_e;
  logic [BwW-1:0]    abw_e;
  logic [IopsW-1:0]  aio_e;
  assign pos_e  = vld_r ? pos_r  : '0;
  assign fill_e = vld_r ? fill_r : '0;
  assign sbw_e  = vld_r ? sbw_r  : '0;
  assign sio_e  = vld_r ? sio_r  : '0;
  assign abw_e  = vld_r ? abw_r  : '0;
  assign aio_e  = vld_r ? aio_r  : '0;

  // Slot written len transactions ago, wrapping around the ring.
  logic [PosW-1:0] old_pos;
  logic [OpW-1:0]  pos_x, old_sum;
  assign pos_x   = OpW'(pos_e);
  assign old_sum = (pos_x >= OpW'(len)) ? pos_x - OpW'(len)
                                        : pos_x + OpW'(MAX_WINDOW) - OpW'(len);
  assign old_pos = PosW'(old_sum);

  always_ff @(posedge clk) begin
    if (cmd.rd_ring) begin
      old_bw <= ring_bw[{vi, old_pos}];
      old_io <= ring_iops[{vi, old_pos}];
    end
  end

  assign filling   = !(vld_r && rdy_r);
  assign completes = (32'(fill_e) + 32'd1) >= 32'(len);

  // Numerators for both divisions, zero flag for negative sliding numerator.
  logic [NumW-1:0] num_bw, num_io;
  logic            neg_bw, neg_io;
  logic [NumW-1:0] prod_bw, prod_io;
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      prod_bw <= NumW'(abw_e) * NumW'(len);
      prod_io <= NumW'(aio_e) * NumW'(len);
    end
  end

  logic [NumW-1:0] sl_bw, sl_io;
  assign sl_bw = prod_bw + NumW'(bw);
  assign sl_io = prod_io + NumW'(io);

  always_comb begin
    neg_bw = 1'b0;
    neg_io = 1'b0;
    if (filling) begin
      num_bw = NumW'(sbw_e) + NumW'(bw);
      num_io = NumW'(sio_e) + NumW'(io);
    end else begin
      neg_bw = sl_bw < NumW'(old_bw);
      neg_io = sl_io < NumW'(old_io);
      num_bw = sl_bw - NumW'(old_bw) + NumW'(len >> 1);
      num_io = sl_io - NumW'(old_io) + NumW'(len >> 1);
    end
  end

  // Shared restoring divider: both quotients one bit per cycle.
  logic [NumW-1:0]    rem_bw, rem_io, q_bw, q_io;
  logic [DivCntW-1:0] cnt;
  logic               busy, zb, zi;
  logic [NumW:0]      tb, ti;
  assign tb = {rem_bw, q_bw[NumW-1]} - (NumW+1)'(len);
  assign ti = {rem_io, q_io[NumW-1]} - (NumW+1)'(len);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (cmd.div_start) begin
      busy   <= 1'b1;
      cnt    <= DivCntW'(NumW - 1);
      rem_bw <= '0;
      rem_io <= '0;
      q_bw   <= num_bw;
      q_io   <= num_io;
      zb     <= neg_bw;
      zi     <= neg_io;
    end else if (busy) begin
      if (!tb[NumW]) begin
        rem_bw <= tb[NumW-1:0];
        q_bw   <= {q_bw[NumW-2:0], 1'b1};
      end else begin
        rem_bw <= {rem_bw[NumW-2:0], q_bw[NumW-1]};
        q_bw   <= {q_bw[NumW-2:0], 1'b0};
      end
      if (!ti[NumW]) begin
        rem_io <= ti[NumW-1:0];
        q_io   <= {q_io[NumW-2:0], 1'b1};
      end else begin
        rem_io <= {rem_io[NumW-2:0], q_io[NumW-1]};
        q_io   <= {q_io[NumW-2:0], 1'b0};
      end
      if (cnt == '0) busy <= 1'b0;
      else cnt <= cnt - 1'b1;
    end
  end

  assign sts.div_done = busy && (cnt == '0) ? 1'b0 : (!busy);

  logic [BwW-1:0]   new_abw;
  logic [IopsW-1:0] new_aio;
  always_comb begin
    if (zb) new_abw = '0;
    else if (q_bw > NumW'({BwW{1'b1}})) new_abw = '1;
    else new_abw = q_bw[BwW-1:0];
    if (zi) new_aio = '0;
    else if (q_io > NumW'({IopsW{1'b1}})) new_aio = '1;
    else new_aio = q_io[IopsW-1:0];
  end

  logic upd_avg, new_rdy;
  assign upd_avg = !filling || completes;
  assign new_rdy = !filling || completes;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      rdy <= '0;
    end else if (cmd.commit && in_range) begin
      vld[vi] <= 1'b1;
      rdy[vi] <= new_rdy;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (in_range) begin
        ring_bw[{vi, pos_e}]   <= bw;
        ring_iops[{vi, pos_e}] <= io;
        pos_mem[vi]  <= (pos_e == PosW'(MAX_WINDOW - 1)) ? '0 : pos_e + 1'b1;
        fill_mem[vi] <= (filling && !completes) ? fill_e + 1'b1 : fill_e;
        sbw_mem[vi]  <= (filling && !completes) ? sbw_e + SumBwW'(bw) : sbw_e;
        sio_mem[vi]  <= (filling && !completes) ? sio_e + SumIoW'(io) : sio_e;
        abw_mem[vi]  <= upd_avg ? new_abw : abw_e;
        aio_mem[vi]  <= upd_avg ? new_aio : aio_e;
        ready_res    <= new_rdy;
        avg_bw       <= upd_avg ? new_abw : abw_e;
        avg_iops     <= upd_avg ? new_aio : aio_e;
      end else begin
        ready_res <= 1'b0;
        avg_bw    <= '0;
        avg_iops  <= '0;
      end
    end
  end
endmodule

// File: design/per_volume_moving_average.sv
// ----------------------------------------------------------------------------
// Per-volume moving average
// Each transaction runs lookup, ring read, setup, the 48-step shared divider
// that forms both averages, and commit; one transaction is in work at a time,
// so a new one is accepted once the last has committed, later only while a
// finished result waits for a previous one still held in the result register.
// Synchronous reset clears all per-volume state through valid bits at once.
// ----------------------------------------------------------------------------
module per_volume_moving_average #(
  parameter int VOLUMES    = pvma_pkg::VolumesDefault,
  parameter int MAX_WINDOW = pvma_pkg::MaxWindowDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,     // window_length
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,       // volume_id[5:0], bw_sample[45:6], iops_sample[77:46]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata        // ready_res[0], avg_bw[40:1], avg_iops[72:41]
);
  import pvma_pkg::*;

  logic [LenW-1:0] window_length;
  pvma_cmd_t cmd;
  pvma_sts_t sts;
  logic             ready_res;
  logic [BwW-1:0]   avg_bw;
  logic [IopsW-1:0] avg_iops;

  always_ff @(posedge clk) begin
    if (rst) window_length <= LenReset;
    else if (cfg_we) window_length <= cfg_wdata;
  end

  pvma_ctrl u_ctrl (
    .clk, .rst, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .cmd, .sts
  );

  pvma_datapath #(.VOLUMES(VOLUMES), .MAX_WINDOW(MAX_WINDOW)) u_dp (
    .clk, .rst, .window_length,
    .volume_id(s_tdata[5:0]), .bw_sample(s_tdata[45:6]), .iops_sample(s_tdata[77:46]),
    .cmd, .sts, .ready_res, .avg_bw, .avg_iops
  );

  assign m_tdata = {7'd0, avg_iops, avg_bw, ready_res};
endmodule
